### design/tcprx_pkg.sv
// ----------------------------------------------------------------------------
// tcprx_pkg
// Types, codes and sizes shared by the TCP receive connection tracker.
// ----------------------------------------------------------------------------
package tcprx_pkg;

  localparam int FQ_DEPTH  = 2;
  localparam int FQ_PTR_W  = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_PTR_W  = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] INITIAL_MSS_RST    = 16'd1460;
  localparam logic [15:0] OWN_WINDOW_MAX_RST = 16'hFFFF;
  localparam logic [7:0]  CWND_MAX_RST       = 8'd64;
  localparam logic [31:0] PEER_START_SEQ_RST = 32'd0;
  localparam logic [7:0]  CWND_RST           = 8'd1;

  typedef enum logic [1:0] {
    CMD_SEGMENT = 2'd0,
    CMD_CLOSE   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_MSS    = 2'd0,
    CFG_OWN_WINDOW_MAX = 2'd1,
    CFG_CWND_MAX       = 2'd2,
    CFG_PEER_START_SEQ = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ESTABLISHED = 3'd0,
    ST_FIN_WAIT_1  = 3'd1,
    ST_FIN_WAIT_2  = 3'd2,
    ST_CLOSING     = 3'd3,
    ST_CLOSE_WAIT  = 3'd4,
    ST_LAST_ACK    = 3'd5,
    ST_CLOSED      = 3'd6
  } conn_state_t;

  typedef enum logic [3:0] {
    ACT_DROP       = 4'd0,
    ACT_RETX       = 4'd1,
    ACT_ACK        = 4'd2,
    ACT_ACCEPT     = 4'd3,
    ACT_ACCEPT_ACK = 4'd4,
    ACT_RESET      = 4'd5,
    ACT_FIN        = 4'd6,
    ACT_IGNORE     = 4'd7,
    ACT_CREDIT     = 4'd8
  } action_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        checks_ok;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic        ack_bit;
    logic        fin_bit;
    logic        rst_bit;
    logic [15:0] peer_window_in;
    logic [15:0] byte_count;
    logic [15:0] mss_option;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  action;
    logic        deliver;
    logic [31:0] ack_out;
    logic [15:0] adv_window;
    logic [2:0]  conn_state;
    logic [31:0] release_below;
    logic [15:0] send_limit;
  } out_word_t;

  typedef struct packed {
    cmd_t        kind;
    logic        checks_ok;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic        ack_bit;
    logic        fin_bit;
    logic        rst_bit;
    logic [15:0] peer_window_in;
    logic [15:0] byte_count;
    logic        len_nz;
    logic [15:0] mss_option;
    logic        mss_nz;
    logic [31:0] seq_adv;
    logic [31:0] seq_adv_fin;
  } fe_word_t;

  typedef struct packed {
    action_t     action;
    logic        deliver;
    logic [31:0] ack_out;
    logic [15:0] adv_window;
    conn_state_t conn_state;
    logic [31:0] release_below;
    logic [7:0]  cwnd;
    logic [15:0] seg_size;
    logic [15:0] peer_window;
  } res_word_t;

endpackage

### design/tcp_receive_connection_tracker.sv
// ----------------------------------------------------------------------------
// tcp_receive_connection_tracker
// Receive-side tracker for one established TCP connection.
//
//   channel   handshake                 payload
//   input     push / full               in_data  (in_word_t)
//   result    pop / empty               out_data (out_word_t)
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word is accepted every cycle while full is low; each gives one result word.
// A result passes the front queue, the combinational execute stage, the stage
// register feeding the send-limit logic, then the result queue to out_data.
// The state update loop in the execute stage sets the one-word-per-cycle rate.
// Reset is synchronous; no clearing pass, cfg_ready is always high.
// A stalled result side fills the result queue, then the front queue, then
// raises full.
// ----------------------------------------------------------------------------
module tcp_receive_connection_tracker import tcprx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_word_t             in_data,
  output logic                 empty,
  input  logic                 pop,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic      fq_valid;
  fe_word_t  fq_word;
  logic      fq_take;
  logic      room;
  logic      res_valid;
  res_word_t res_word;

  tcprx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .fq_valid (fq_valid),
    .fq_word  (fq_word),
    .fq_take  (fq_take)
  );

  tcprx_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fq_valid  (fq_valid),
    .fq_word   (fq_word),
    .fq_take   (fq_take),
    .room      (room),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  tcprx_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_word  (res_word),
    .room      (room),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

### design/tcprx_front.sv
// ----------------------------------------------------------------------------
// tcprx_front
// Accepts input words, decodes the command, precomputes sequence advances
// and holds them in a short queue for the execute stage.
// ----------------------------------------------------------------------------
module tcprx_front import tcprx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_word_t in_data,
  output logic     fq_valid,
  output fe_word_t fq_word,
  input  logic     fq_take
);

  fe_word_t            fq_mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_CNT_W-1:0] count;
  fe_word_t            dec;
  logic [16:0]         len_plus1;
  logic                wr_en;
  logic                rd_en;

  always_comb begin
    len_plus1          = {1'b0, in_data.byte_count} + 17'd1;
    dec.kind           = cmd_t'(in_data.cmd);
    dec.checks_ok      = in_data.checks_ok;
    dec.seq_num        = in_data.seq_num;
    dec.ack_num        = in_data.ack_num;
    dec.ack_bit        = in_data.ack_bit;
    dec.fin_bit        = in_data.fin_bit;
    dec.rst_bit        = in_data.rst_bit;
    dec.peer_window_in = in_data.peer_window_in;
    dec.byte_count     = in_data.byte_count;
    dec.len_nz         = (in_data.byte_count != 16'd0);
    dec.mss_option     = in_data.mss_option;
    dec.mss_nz         = (in_data.mss_option != 16'd0);
    dec.seq_adv        = in_data.seq_num + 32'(in_data.byte_count);
    dec.seq_adv_fin    = in_data.seq_num + 32'(len_plus1);
  end

  assign full     = (count == FQ_CNT_W'(FQ_DEPTH));
  assign fq_valid = (count != '0);
  assign fq_word  = fq_mem[rd_ptr];
  assign wr_en    = push && !full;
  assign rd_en    = fq_take && fq_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fq_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/tcprx_exec.sv
// ----------------------------------------------------------------------------
// tcprx_exec
// Connection state, configuration registers and per-word decision logic.
// ----------------------------------------------------------------------------
module tcprx_exec import tcprx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 fq_valid,
  input  fe_word_t             fq_word,
  output logic                 fq_take,
  input  logic                 room,
  output logic                 res_valid,
  output res_word_t            res_word
);

  logic [15:0] own_window_max;
  logic [7:0]  cwnd_max;

  conn_state_t conn_mode,     conn_mode_next;
  logic [31:0] expected_seq,  expected_seq_next;
  logic [31:0] last_ack_seen, last_ack_seen_next;
  logic [15:0] peer_window,   peer_window_next;
  logic [7:0]  cwnd,          cwnd_next;
  logic [15:0] seg_size,      seg_size_next;
  logic [15:0] own_window,    own_window_next;
  logic        read_closed,   read_closed_next;
  logic        write_closed,  write_closed_next;

  action_t     action;
  logic        deliver;
  logic        fin_ok;
  logic [8:0]  cwnd_up;
  logic [16:0] ow_sum;

  assign cfg_ready = 1'b1;
  assign fq_take   = fq_valid && room;
  assign res_valid = fq_take;

  always_comb begin
    conn_mode_next     = conn_mode;
    expected_seq_next  = expected_seq;
    last_ack_seen_next = last_ack_seen;
    peer_window_next   = peer_window;
    cwnd_next          = cwnd;
    seg_size_next      = seg_size;
    own_window_next    = own_window;
    read_closed_next   = read_closed;
    write_closed_next  = write_closed;
    action             = ACT_IGNORE;
    deliver            = 1'b0;
    fin_ok             = fq_word.fin_bit && (conn_mode == ST_ESTABLISHED ||
                         conn_mode == ST_FIN_WAIT_1 || conn_mode == ST_FIN_WAIT_2);
    cwnd_up            = {1'b0, cwnd} + 9'd1;
    ow_sum             = {1'b0, own_window} + {1'b0, fq_word.byte_count};

    unique case (fq_word.kind)
      CMD_SEGMENT: begin
        priority if (conn_mode == ST_CLOSED) begin
          action = ACT_IGNORE;
        end else if (!fq_word.checks_ok) begin
          action = ACT_DROP;
        end else if (fq_word.ack_bit && fq_word.ack_num == last_ack_seen) begin
          action = ACT_RETX;
        end else if (fq_word.seq_num != expected_seq) begin
          action = ACT_ACK;
        end else if (fq_word.rst_bit) begin
          read_closed_next  = 1'b1;
          write_closed_next = 1'b1;
          conn_mode_next    = ST_CLOSED;
          action            = ACT_RESET;
        end else begin
          if (fq_word.len_nz) begin
            deliver         = 1'b1;
            own_window_next = (own_window > fq_word.byte_count) ?
                              own_window - fq_word.byte_count : 16'd0;
          end
          expected_seq_next = fin_ok ? fq_word.seq_adv_fin : fq_word.seq_adv;
          if (fq_word.ack_bit) begin
            last_ack_seen_next = fq_word.ack_num;
          end
          peer_window_next = fq_word.peer_window_in;
          cwnd_next        = (cwnd_up > {1'b0, cwnd_max}) ? cwnd_max : cwnd_up[7:0];
          if (fq_word.mss_nz && fq_word.mss_option < seg_size) begin
            seg_size_next = fq_word.mss_option;
          end
          if (fin_ok) begin
            read_closed_next = 1'b1;
            priority if (conn_mode == ST_ESTABLISHED) begin
              conn_mode_next = ST_CLOSE_WAIT;
            end else if (conn_mode == ST_FIN_WAIT_1 && !fq_word.ack_bit) begin
              conn_mode_next = ST_CLOSING;
            end else begin
              conn_mode_next = ST_CLOSED;
            end
            action = ACT_ACCEPT_ACK;
          end else if (!fq_word.len_nz) begin
            if (conn_mode == ST_CLOSING || conn_mode == ST_LAST_ACK) begin
              conn_mode_next = ST_CLOSED;
            end else if (conn_mode == ST_FIN_WAIT_1) begin
              conn_mode_next = ST_FIN_WAIT_2;
            end
            action = ACT_ACCEPT;
          end else begin
            action = ACT_ACCEPT_ACK;
          end
        end
      end
      CMD_CLOSE: begin
        if (conn_mode == ST_ESTABLISHED) begin
          conn_mode_next    = ST_FIN_WAIT_1;
          write_closed_next = 1'b1;
          action            = ACT_FIN;
        end else if (conn_mode == ST_CLOSE_WAIT) begin
          conn_mode_next    = ST_LAST_ACK;
          write_closed_next = 1'b1;
          action            = ACT_FIN;
        end
      end
      CMD_READ: begin
        own_window_next = (ow_sum > {1'b0, own_window_max}) ? own_window_max : ow_sum[15:0];
        action          = ACT_CREDIT;
      end
      default: begin
        action = ACT_IGNORE;
      end
    endcase

    res_word.action        = action;
    res_word.deliver       = deliver;
    res_word.ack_out       = expected_seq_next;
    res_word.adv_window    = own_window_next;
    res_word.conn_state    = conn_mode_next;
    res_word.release_below = last_ack_seen_next;
    res_word.cwnd          = cwnd_next;
    res_word.seg_size      = seg_size_next;
    res_word.peer_window   = peer_window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_window_max <= OWN_WINDOW_MAX_RST;
      cwnd_max       <= CWND_MAX_RST;
      conn_mode      <= ST_ESTABLISHED;
      expected_seq   <= PEER_START_SEQ_RST;
      last_ack_seen  <= '0;
      peer_window    <= '0;
      cwnd           <= CWND_RST;
      seg_size       <= INITIAL_MSS_RST;
      own_window     <= OWN_WINDOW_MAX_RST;
      read_closed    <= 1'b0;
      write_closed   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INITIAL_MSS: begin
          seg_size <= cfg_data[15:0];
        end
        CFG_OWN_WINDOW_MAX: begin
          own_window_max <= cfg_data[15:0];
          own_window     <= cfg_data[15:0];
        end
        CFG_CWND_MAX: begin
          cwnd_max <= cfg_data[7:0];
        end
        CFG_PEER_START_SEQ: begin
          expected_seq <= cfg_data;
        end
        default: begin
          cwnd_max <= cwnd_max;
        end
      endcase
    end else if (fq_take) begin
      conn_mode     <= conn_mode_next;
      expected_seq  <= expected_seq_next;
      last_ack_seen <= last_ack_seen_next;
      peer_window   <= peer_window_next;
      cwnd          <= cwnd_next;
      seg_size      <= seg_size_next;
      own_window    <= own_window_next;
      read_closed   <= read_closed_next;
      write_closed  <= write_closed_next;
    end
  end

  a_read_closed_mode: assert property (@(posedge clk) disable iff (rst)
    read_closed |-> (conn_mode == ST_CLOSING || conn_mode == ST_CLOSE_WAIT ||
                     conn_mode == ST_LAST_ACK || conn_mode == ST_CLOSED))
    else $error("read side closed in an open receive state");

  a_write_closed_mode: assert property (@(posedge clk) disable iff (rst)
    write_closed |-> (conn_mode == ST_FIN_WAIT_1 || conn_mode == ST_FIN_WAIT_2 ||
                      conn_mode == ST_CLOSING || conn_mode == ST_LAST_ACK ||
                      conn_mode == ST_CLOSED))
    else $error("write side closed in an open send state");

  a_closed_holds: assert property (@(posedge clk) disable iff (rst)
    (fq_take && conn_mode == ST_CLOSED) |=> (conn_mode == ST_CLOSED))
    else $error("closed connection reopened");

endmodule

### design/tcprx_outq.sv
// ----------------------------------------------------------------------------
// tcprx_outq
// Registers each result, computes the send limit and queues result words.
// ----------------------------------------------------------------------------
module tcprx_outq import tcprx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  input  res_word_t res_word,
  output logic      room,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_data
);

  res_word_t           stage;
  logic                stage_v;
  out_word_t           oq_mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic [OQ_CNT_W:0]   pending;
  logic [23:0]         prod;
  out_word_t           fill;
  logic                rd_en;

  assign pending  = {1'b0, count} + (OQ_CNT_W + 1)'(stage_v);
  assign room     = (pending < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign empty    = (count == '0);
  assign out_data = oq_mem[rd_ptr];
  assign rd_en    = pop && !empty;

  always_comb begin
    prod               = 24'(stage.cwnd) * 24'(stage.seg_size);
    fill.action        = stage.action;
    fill.deliver       = stage.deliver;
    fill.ack_out       = stage.ack_out;
    fill.adv_window    = stage.adv_window;
    fill.conn_state    = stage.conn_state;
    fill.release_below = stage.release_below;
    fill.send_limit    = (prod > 24'(stage.peer_window)) ? stage.peer_window : prod[15:0];
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      stage <= res_word;
    end
    if (stage_v) begin
      oq_mem[wr_ptr] <= fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
    end else begin
      stage_v <= res_valid;
      if (stage_v) begin
        wr_ptr <= (wr_ptr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (stage_v && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !stage_v) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stage_v |-> (count < OQ_CNT_W'(OQ_DEPTH) || rd_en))
    else $error("result queue overflow");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the TCP receive connection tracker. A scoreboard class keeps
// its own copy of the connection state and builds the expected result word
// for each accepted input word; every popped result is compared field by
// field. Directed words cover the edge cases, random phases under several
// register settings follow, and a last phase walks the close states.
// ----------------------------------------------------------------------------
module tb;
  import tcprx_pkg::*;

  class conn_scoreboard;
    logic [15:0] initial_mss;
    logic [15:0] own_win_max;
    logic [7:0]  cwnd_max;
    logic [31:0] peer_start_seq;
    conn_state_t mode;
    logic [31:0] exp_seq;
    logic [31:0] peer_acked;
    logic [15:0] peer_win;
    logic [7:0]  cwnd;
    logic [15:0] seg_size;
    logic [15:0] own_win;
    logic        read_closed;
    logic        write_closed;
    out_word_t   expected_q[$];
    int          errors;

    function new();
      initial_mss    = INITIAL_MSS_RST;
      own_win_max    = OWN_WINDOW_MAX_RST;
      cwnd_max       = CWND_MAX_RST;
      peer_start_seq = PEER_START_SEQ_RST;
      mode           = ST_ESTABLISHED;
      exp_seq        = PEER_START_SEQ_RST;
      peer_acked     = '0;
      peer_win       = '0;
      cwnd           = CWND_RST;
      seg_size       = INITIAL_MSS_RST;
      own_win        = OWN_WINDOW_MAX_RST;
      read_closed    = 1'b0;
      write_closed   = 1'b0;
      errors         = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        CFG_INITIAL_MSS: begin
          initial_mss = data[15:0];
          seg_size    = data[15:0];
        end
        CFG_OWN_WINDOW_MAX: begin
          own_win_max = data[15:0];
          own_win     = data[15:0];
        end
        CFG_CWND_MAX: cwnd_max = data[7:0];
        CFG_PEER_START_SEQ: begin
          peer_start_seq = data;
          exp_seq        = data;
        end
        default: ;
      endcase
    endfunction

    function void take_segment(in_word_t w, int unsigned adv);
      exp_seq = w.seq_num + adv;
      if (w.ack_bit)
        peer_acked = w.ack_num;
      peer_win = w.peer_window_in;
      if (int'(cwnd) + 1 > int'(cwnd_max))
        cwnd = cwnd_max;
      else
        cwnd = cwnd + 8'd1;
      if (w.mss_option != 16'd0 && w.mss_option < seg_size)
        seg_size = w.mss_option;
    endfunction

    function void note_word(in_word_t w);
      out_word_t   r;
      action_t     act;
      logic        dlv;
      int unsigned len;
      int unsigned win;
      longint      lim;
      act = ACT_IGNORE;
      dlv = 1'b0;
      len = 32'(w.byte_count);
      if (w.cmd == CMD_SEGMENT) begin
        if (mode == ST_CLOSED)
          act = ACT_IGNORE;
        else if (!w.checks_ok)
          act = ACT_DROP;
        else if (w.ack_bit && w.ack_num == peer_acked)
          act = ACT_RETX;
        else if (w.seq_num != exp_seq)
          act = ACT_ACK;
        else if (w.rst_bit) begin
          read_closed  = 1'b1;
          write_closed = 1'b1;
          mode         = ST_CLOSED;
          act          = ACT_RESET;
        end else begin
          if (len != 0) begin
            dlv     = 1'b1;
            own_win = (own_win > len) ? 16'(own_win - len) : 16'd0;
          end
          if (w.fin_bit && (mode == ST_ESTABLISHED || mode == ST_FIN_WAIT_1 ||
                            mode == ST_FIN_WAIT_2)) begin
            take_segment(w, len + 1);
            read_closed = 1'b1;
            if (mode == ST_ESTABLISHED)
              mode = ST_CLOSE_WAIT;
            else if (mode == ST_FIN_WAIT_1 && !w.ack_bit)
              mode = ST_CLOSING;
            else
              mode = ST_CLOSED;
            act = ACT_ACCEPT_ACK;
          end else begin
            take_segment(w, len);
            if (len == 0) begin
              if (mode == ST_CLOSING || mode == ST_LAST_ACK)
                mode = ST_CLOSED;
              else if (mode == ST_FIN_WAIT_1)
                mode = ST_FIN_WAIT_2;
              act = ACT_ACCEPT;
            end else begin
              act = ACT_ACCEPT_ACK;
            end
          end
        end
      end else if (w.cmd == CMD_CLOSE) begin
        if (mode == ST_ESTABLISHED) begin
          mode         = ST_FIN_WAIT_1;
          write_closed = 1'b1;
          act          = ACT_FIN;
        end else if (mode == ST_CLOSE_WAIT) begin
          mode         = ST_LAST_ACK;
          write_closed = 1'b1;
          act          = ACT_FIN;
        end
      end else if (w.cmd == CMD_READ) begin
        win     = own_win + len;
        own_win = (win > own_win_max) ? own_win_max : 16'(win);
        act     = ACT_CREDIT;
      end
      lim = longint'(cwnd) * longint'(seg_size);
      if (lim > peer_win)
        lim = longint'(peer_win);
      if (lim > 65535)
        lim = 65535;
      r.action        = act;
      r.deliver       = dlv;
      r.ack_out       = exp_seq;
      r.adv_window    = own_win;
      r.conn_state    = mode;
      r.release_below = peer_acked;
      r.send_limit    = 16'(lim);
      expected_q.push_back(r);
    endfunction

    function void flag_error(string msg);
      if (errors < 10)
        $display("%s", msg);
      errors++;
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result word: act=%0d ack=%h state=%0d",
                             got.action, got.ack_out, got.conn_state));
        return;
      end
      want = expected_q.pop_front();
      if (got.action !== want.action || got.deliver !== want.deliver ||
          got.ack_out !== want.ack_out || got.adv_window !== want.adv_window ||
          got.conn_state !== want.conn_state ||
          got.release_below !== want.release_below ||
          got.send_limit !== want.send_limit)
        flag_error($sformatf({"result mismatch\n",
                              "  expected act=%0d dlv=%0b ack=%h win=%0d st=%0d rel=%h lim=%0d\n",
                              "  actual   act=%0d dlv=%0b ack=%h win=%0d st=%0d rel=%h lim=%0d"},
                             want.action, want.deliver, want.ack_out, want.adv_window,
                             want.conn_state, want.release_below, want.send_limit,
                             got.action, got.deliver, got.ack_out, got.adv_window,
                             got.conn_state, got.release_below, got.send_limit));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  in_word_t             in_data;
  logic                 empty;
  logic                 pop;
  out_word_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  conn_scoreboard sb = new();
  bit             idle_on = 1'b1;
  bit             stall_req = 1'b0;
  int             stall_left = 0;

  tcp_receive_connection_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // hold pop low for a long stretch on request, else pop with random gaps while idle_on
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_left = 200;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(idle_on && $urandom_range(0, 99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_word(out_data);
  end

  function automatic in_word_t seg_word(logic [31:0] seq, logic [31:0] ack, logic ackb,
                                        logic fin, logic rstb, logic [15:0] win,
                                        logic [15:0] len, logic [15:0] mss);
    in_word_t w;
    w.cmd            = CMD_SEGMENT;
    w.checks_ok      = 1'b1;
    w.seq_num        = seq;
    w.ack_num        = ack;
    w.ack_bit        = ackb;
    w.fin_bit        = fin;
    w.rst_bit        = rstb;
    w.peer_window_in = win;
    w.byte_count     = len;
    w.mss_option     = mss;
    return w;
  endfunction

  function automatic in_word_t cmd_word(cmd_t c, logic [15:0] len);
    in_word_t w;
    w            = '0;
    w.cmd        = c;
    w.byte_count = len;
    return w;
  endfunction

  function automatic logic [15:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20)
      return 16'd0;
    else if (r < 75)
      return 16'($urandom_range(1, 1460));
    else if (r < 85)
      return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic in_word_t make_word(int fin_pct, int close_pct, int rst_pct);
    in_word_t w;
    int       pick;
    int       r;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      w.cmd            = 2'($urandom_range(0, 3));
      w.checks_ok      = 1'($urandom);
      w.seq_num        = $urandom;
      w.ack_num        = $urandom;
      w.ack_bit        = 1'($urandom);
      w.fin_bit        = 1'($urandom);
      w.rst_bit        = 1'($urandom);
      w.peer_window_in = 16'($urandom);
      w.byte_count     = 16'($urandom);
      w.mss_option     = 16'($urandom);
      if (close_pct == 0 && w.cmd == CMD_CLOSE)
        w.cmd = CMD_NONE;
      return w;
    end
    if (pick < 22)
      return cmd_word(CMD_READ, rand_len());
    if (pick < 22 + close_pct)
      return cmd_word(CMD_CLOSE, 16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 78)
      w = seg_word(sb.exp_seq, '0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    else if (r < 89)
      w = seg_word(sb.exp_seq + $urandom_range(1, 70000), '0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    else
      w = seg_word(sb.exp_seq - $urandom_range(1, 70000), '0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    w.checks_ok = ($urandom_range(0, 99) >= 4);
    w.ack_bit   = ($urandom_range(0, 9) != 0);
    w.ack_num   = ($urandom_range(0, 9) == 0) ? sb.peer_acked
                                              : sb.peer_acked + $urandom_range(1, 5000);
    w.fin_bit   = ($urandom_range(0, 99) < fin_pct);
    w.rst_bit   = ($urandom_range(0, 99) < rst_pct);
    r = $urandom_range(0, 99);
    w.peer_window_in = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : 16'($urandom);
    w.byte_count     = rand_len();
    r = $urandom_range(0, 99);
    w.mss_option = (r < 70) ? 16'd0 : (r < 90) ? 16'($urandom_range(536, 1460))
                                               : 16'($urandom);
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 9) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    sb.note_word(w);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [15:0] mss, logic [15:0] win_max, logic [7:0] cmax,
                           logic [31:0] start_seq);
    write_cfg(CFG_INITIAL_MSS, {16'd0, mss});
    write_cfg(CFG_OWN_WINDOW_MAX, {16'd0, win_max});
    write_cfg(CFG_CWND_MAX, {24'd0, cmax});
    write_cfg(CFG_PEER_START_SEQ, start_seq);
  endtask

  // drop push, wait for every result, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(int count, int fin_pct, int close_pct, int rst_pct);
    repeat (count) send_word(make_word(fin_pct, close_pct, rst_pct));
  endtask

  initial begin
    in_word_t w;
    int       n;
    rst       = 1'b1;
    push      = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(16'hFFFF, 16'd1000, 8'd255, 32'hFFFF_FF00);
    send_word(cmd_word(CMD_NONE, 16'hFFFF));
    w = seg_word(sb.exp_seq, 32'h1, 1'b1, 1'b0, 1'b0, 16'd100, 16'd10, 16'd0);
    w.checks_ok = 1'b0;
    send_word(w);
    send_word(seg_word(sb.exp_seq, 32'h0, 1'b1, 1'b0, 1'b0, 16'd500, 16'd20, 16'd0));
    send_word(seg_word(sb.exp_seq, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
    send_word(seg_word(sb.exp_seq, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 16'hFFFF, 16'd200,
                       16'hFFFF));
    send_word(seg_word(sb.exp_seq - 1, 32'h10, 1'b1, 1'b0, 1'b0, 16'd10, 16'd5, 16'd0));
    send_word(seg_word(sb.exp_seq + 32'h8000_0000, 32'h20, 1'b1, 1'b0, 1'b0, 16'd10, 16'd5,
                       16'd0));
    send_word(seg_word(32'hFFFF_FFFF, 32'h30, 1'b1, 1'b0, 1'b0, 16'd10, 16'd5, 16'd0));
    send_word(seg_word(sb.exp_seq, sb.peer_acked + 1, 1'b1, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF,
                       16'd1));
    send_word(cmd_word(CMD_READ, 16'd0));
    send_word(cmd_word(CMD_READ, 16'hFFFF));
    send_word(cmd_word(CMD_READ, 16'd300));
    send_word(seg_word(sb.exp_seq, 32'h5555_AAAA, 1'b0, 1'b0, 1'b0, 16'd1, 16'd1, 16'd0));
    send_word(seg_word(32'h1234_5678, sb.peer_acked, 1'b1, 1'b0, 1'b0, 16'd7, 16'd7, 16'd7));
    w = '1;
    w.cmd = CMD_SEGMENT;
    w.checks_ok = 1'b0;
    send_word(w);
    w = '1;
    send_word(w);
    send_word(seg_word(sb.exp_seq, sb.peer_acked + 2, 1'b1, 1'b0, 1'b0, 16'd4000, 16'd0,
                       16'd2));
    send_word(seg_word(sb.exp_seq, 32'hAAAA_5555, 1'b1, 1'b0, 1'b0, 16'hAAAA, 16'd1460,
                       16'd1460));

    drain();
    configure(16'd1460, 16'hFFFF, 8'd64, $urandom);
    run_phase(60, 0, 0, 0);
    stall_req = 1'b1;
    run_phase(60, 0, 0, 0);

    drain();
    configure(16'd1, 16'd1, 8'd1, 32'd0);
    run_phase(120, 0, 0, 0);

    drain();
    configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
              8'($urandom_range(1, 255)), $urandom);
    run_phase(60, 0, 0, 0);
    drain();
    run_phase(60, 0, 0, 0);

    drain();
    idle_on = 1'b0;
    configure(16'hFFFF, 16'hFFFF, 8'd255, 32'hFFFF_FFFF);
    run_phase(120, 0, 0, 0);
    drain();
    idle_on = 1'b1;

    // walk the close states until the connection is gone or 200 words are sent
    configure(16'($urandom_range(536, 65535)), 16'($urandom_range(1, 65535)),
              8'($urandom_range(1, 255)), $urandom);
    n = 0;
    while (sb.mode != ST_CLOSED && n < 200) begin
      send_word(make_word(10, 6, 1));
      n++;
    end
    run_phase(12, 10, 10, 5);

    drain();
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
